[sv/utt_pkg.sv]
// Shared types and constants for the UTF-16 to UTF-8 transcoder.
package utt_pkg;

  // Most UTF-8 bytes that one input byte can cause
  localparam int unsigned JOB_BYTES = 6;

  // Configuration register word indexes
  localparam logic REG_BIG_ENDIAN = 1'b0;

  // UTF-16 code unit boundaries
  localparam logic [15:0] BOM_UNIT        = 16'hFEFF;
  localparam logic [15:0] HIGH_SURR_FIRST = 16'hD800;
  localparam logic [15:0] HIGH_SURR_LAST  = 16'hDBFF;
  localparam logic [15:0] LOW_SURR_FIRST  = 16'hDC00;
  localparam logic [15:0] LOW_SURR_LAST   = 16'hDFFF;
  localparam logic [15:0] ONE_BYTE_LIMIT  = 16'h0080;
  localparam logic [15:0] TWO_BYTE_LIMIT  = 16'h0800;

  // Supplementary plane offset
  localparam logic [20:0] SUPP_BASE = 21'h10000;

  // High surrogate prefix above the ten payload bits
  localparam logic [5:0] HIGH_SURR_PREFIX = 6'b110110;

  // UTF-8 lead and continuation markers
  localparam logic [7:0] LEAD2 = 8'hC0;
  localparam logic [7:0] LEAD3 = 8'hE0;
  localparam logic [7:0] LEAD4 = 8'hF0;
  localparam logic [7:0] CONT  = 8'h80;

  // Replacement character EF BF BD
  localparam logic [7:0] REPL0 = 8'hEF;
  localparam logic [7:0] REPL1 = 8'hBF;
  localparam logic [7:0] REPL2 = 8'hBD;

  // One classified input byte: the UTF-8 bytes it yields, their count, end flag
  typedef struct packed {
    logic [JOB_BYTES-1:0][7:0] bytes;
    logic [2:0]                count;
    logic                      eos;
  } job_t;

endpackage

[sv/utt_front.sv]
// Front end: pairs bytes into code units and encodes each into a job of UTF-8 bytes.
module utt_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          big_endian,
  input  logic          in_valid,
  input  logic [7:0]    in_byte,
  input  logic          end_of_stream,
  output logic          job_push,
  output utt_pkg::job_t job
);

  logic       odd_phase;
  logic [7:0] held_byte;
  logic       first_pending;
  logic       surr_waiting;
  logic [9:0] high_bits;

  logic       odd_phase_next;
  logic [7:0] held_byte_next;
  logic       first_pending_next;
  logic       surr_waiting_next;
  logic [9:0] high_bits_next;

  logic [15:0] unit;
  logic [20:0] cp;
  logic [15:0] held_surr;
  logic        is_bom;
  logic [2:0]  pos;

  // Assemble the code unit in the selected byte order
  assign unit = big_endian ? {held_byte, in_byte} : {in_byte, held_byte};
  assign cp   = utt_pkg::SUPP_BASE + {1'b0, high_bits, unit[9:0]};
  assign is_bom = first_pending && (unit == utt_pkg::BOM_UNIT);

  // Classify the byte and build its job
  always_comb begin
    odd_phase_next     = odd_phase;
    held_byte_next     = held_byte;
    first_pending_next = first_pending;
    surr_waiting_next  = surr_waiting;
    high_bits_next     = high_bits;
    held_surr          = 16'h0000;
    job                = '0;
    pos                = 3'd0;

    if (!odd_phase) begin
      held_byte_next = in_byte;
      odd_phase_next = 1'b1;
    end else begin
      odd_phase_next     = 1'b0;
      first_pending_next = 1'b0;
      if (!is_bom) begin
        if (surr_waiting && unit inside {[utt_pkg::LOW_SURR_FIRST:utt_pkg::LOW_SURR_LAST]})
        begin
          // Merge the pair into a four-byte sequence
          surr_waiting_next = 1'b0;
          high_bits_next    = 10'd0;
          job.bytes[pos] = utt_pkg::LEAD4 | {5'b0, cp[20:18]};
          pos = pos + 3'd1;
          job.bytes[pos] = utt_pkg::CONT | {2'b0, cp[17:12]};
          pos = pos + 3'd1;
          job.bytes[pos] = utt_pkg::CONT | {2'b0, cp[11:6]};
          pos = pos + 3'd1;
          job.bytes[pos] = utt_pkg::CONT | {2'b0, cp[5:0]};
          pos = pos + 3'd1;
        end else begin
          if (surr_waiting) begin
            // Unpaired high surrogate: emit the replacement character first
            surr_waiting_next = 1'b0;
            high_bits_next    = 10'd0;
            job.bytes[pos] = utt_pkg::REPL0;
            pos = pos + 3'd1;
            job.bytes[pos] = utt_pkg::REPL1;
            pos = pos + 3'd1;
            job.bytes[pos] = utt_pkg::REPL2;
            pos = pos + 3'd1;
          end
          if (unit < utt_pkg::ONE_BYTE_LIMIT) begin
            job.bytes[pos] = unit[7:0];
            pos = pos + 3'd1;
          end else if (unit < utt_pkg::TWO_BYTE_LIMIT) begin
            job.bytes[pos] = utt_pkg::LEAD2 | {3'b0, unit[10:6]};
            pos = pos + 3'd1;
            job.bytes[pos] = utt_pkg::CONT | {2'b0, unit[5:0]};
            pos = pos + 3'd1;
          end else if (unit inside {[utt_pkg::HIGH_SURR_FIRST:utt_pkg::HIGH_SURR_LAST]}
                       && !end_of_stream) begin
            // Hold the high surrogate for its partner
            surr_waiting_next = 1'b1;
            high_bits_next    = unit[9:0];
          end else begin
            job.bytes[pos] = utt_pkg::LEAD3 | {4'b0, unit[15:12]};
            pos = pos + 3'd1;
            job.bytes[pos] = utt_pkg::CONT | {2'b0, unit[11:6]};
            pos = pos + 3'd1;
            job.bytes[pos] = utt_pkg::CONT | {2'b0, unit[5:0]};
            pos = pos + 3'd1;
          end
        end
      end
    end

    if (end_of_stream) begin
      // Flush a still waiting high surrogate in its three-byte form
      if (surr_waiting_next) begin
        held_surr = {utt_pkg::HIGH_SURR_PREFIX, high_bits_next};
        job.bytes[pos] = utt_pkg::LEAD3 | {4'b0, held_surr[15:12]};
        pos = pos + 3'd1;
        job.bytes[pos] = utt_pkg::CONT | {2'b0, held_surr[11:6]};
        pos = pos + 3'd1;
        job.bytes[pos] = utt_pkg::CONT | {2'b0, held_surr[5:0]};
        pos = pos + 3'd1;
      end
      odd_phase_next     = 1'b0;
      held_byte_next     = 8'h00;
      first_pending_next = 1'b1;
      surr_waiting_next  = 1'b0;
      high_bits_next     = 10'd0;
    end

    job.count = pos;
    job.eos   = end_of_stream;
  end

  // Push only bytes that produce output
  assign job_push = in_valid && (pos != 3'd0);

  // Advance the pairing state on each accepted transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      odd_phase     <= 1'b0;
      held_byte     <= 8'h00;
      first_pending <= 1'b1;
      surr_waiting  <= 1'b0;
      high_bits     <= 10'd0;
    end else if (in_valid) begin
      odd_phase     <= odd_phase_next;
      held_byte     <= held_byte_next;
      first_pending <= first_pending_next;
      surr_waiting  <= surr_waiting_next;
      high_bits     <= high_bits_next;
    end
  end

  // The end of a stream leaves the front in its start state
  a_eos_clears: assert property (@(posedge clk) disable iff (rst)
    in_valid && end_of_stream |=> first_pending && !odd_phase && !surr_waiting)
    else $error("front state not cleared after end of stream");

  // A first byte of a unit never yields output unless it ends the stream
  a_first_byte_silent: assert property (@(posedge clk) disable iff (rst)
    in_valid && !odd_phase && !end_of_stream |-> !job_push)
    else $error("first byte of a unit produced output");

endmodule

[sv/utt_queue.sv]
// Job queue between the front end and the byte serializer.
module utt_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  utt_pkg::job_t job_in,
  output logic          full,
  input  logic          pop,
  output logic          job_valid,
  output utt_pkg::job_t job_out
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  utt_pkg::job_t mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full      = (count == CNT_W'(DEPTH));
  assign job_valid = (count != '0);
  assign job_out   = mem[rd_ptr];

  // Store incoming jobs
  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem[wr_ptr] <= job_in;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop && job_valid) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if ((push && !full) && !(pop && job_valid)) begin
        count <= count + 1'b1;
      end else if (!(push && !full) && (pop && job_valid)) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && full))
    else $error("job pushed into a full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !(pop && !job_valid))
    else $error("job popped from an empty queue");

  a_count_grows: assert property (@(posedge clk) disable iff (rst)
    push && !full && !pop |=> count == $past(count) + 1'b1)
    else $error("queue occupancy did not grow on a push");

endmodule

[sv/utt_back.sv]
// Back end: sends the bytes of each job one per cycle while pop is high, through an output register.
module utt_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          job_valid,
  input  utt_pkg::job_t job,
  output logic          job_pop,
  output logic [7:0]    out_byte,
  output logic          run_last,
  output logic          stream_done,
  output logic          empty,
  input  logic          pop
);

  logic [2:0] idx;
  logic       out_valid;
  logic       load;
  logic       is_last;

  assign empty   = !out_valid;
  assign load    = job_valid && (!out_valid || pop);
  assign is_last = (idx == job.count - 3'd1);
  assign job_pop = load && is_last;

  // Step through the head job
  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= 3'd0;
      out_valid <= 1'b0;
    end else if (load) begin
      idx       <= is_last ? 3'd0 : idx + 3'd1;
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  // Load the output register
  always_ff @(posedge clk) begin
    if (load) begin
      out_byte    <= job.bytes[idx];
      run_last    <= is_last;
      stream_done <= job.eos;
    end
  end

  a_job_nonempty: assert property (@(posedge clk) disable iff (rst)
    job_valid |-> job.count != 3'd0)
    else $error("empty job reached the serializer");

  a_idx_in_range: assert property (@(posedge clk) disable iff (rst)
    job_valid |-> idx < job.count)
    else $error("byte index past the end of the job");

  a_last_marks_run: assert property (@(posedge clk) disable iff (rst)
    job_pop |=> !empty && run_last)
    else $error("finished job not marked as last");

endmodule

[sv/utf16_to_utf8_transcoder.sv]
// Top level of the UTF-16 to UTF-8 transcoder: register port, front end, queue, back end.
//
//   channel   direction  handshake             payload
//   config    in         psel/penable/pwrite   paddr, pwdata, prdata (big_endian)
//   input     in         push / full           in_byte, end_of_stream
//   result    out        pop / empty           out_byte, run_last, stream_done
//
// One input byte is taken per cycle while full is low; the front end encodes it
// in that same cycle and queues the UTF-8 bytes it yields (0 to 6).
// The back end sends one result byte per cycle while pop is high, from a single output
// register, so a byte that yields n results holds the result side for n pops.
// full rises when QUEUE_DEPTH jobs wait; a stalled result side holds the output
// register and backs up into the queue. rst is synchronous and clears the
// pairing state, the queue and big_endian; no clearing pass is needed.
module utf16_to_utf8_transcoder #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic [7:0]  in_byte,
  input  logic        end_of_stream,
  input  logic        push,
  output logic        full,
  output logic [7:0]  out_byte,
  output logic        run_last,
  output logic        stream_done,
  output logic        empty,
  input  logic        pop
);

  logic          big_endian;
  logic          in_valid;
  logic          job_push;
  utt_pkg::job_t front_job;
  logic          job_valid;
  utt_pkg::job_t head_job;
  logic          job_pop;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == utt_pkg::REG_BIG_ENDIAN) ? 32'(big_endian) : 32'h0;

  // Write the byte order register
  always_ff @(posedge clk) begin
    if (rst) begin
      big_endian <= 1'b0;
    end else if (psel && penable && pwrite && pready
                 && paddr[2] == utt_pkg::REG_BIG_ENDIAN) begin
      big_endian <= pwdata[0];
    end
  end

  assign in_valid = push && !full;

  utt_front u_front (
    .clk          (clk),
    .rst          (rst),
    .big_endian   (big_endian),
    .in_valid     (in_valid),
    .in_byte      (in_byte),
    .end_of_stream(end_of_stream),
    .job_push     (job_push),
    .job          (front_job)
  );

  utt_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (job_push),
    .job_in   (front_job),
    .full     (full),
    .pop      (job_pop),
    .job_valid(job_valid),
    .job_out  (head_job)
  );

  utt_back u_back (
    .clk        (clk),
    .rst        (rst),
    .job_valid  (job_valid),
    .job        (head_job),
    .job_pop    (job_pop),
    .out_byte   (out_byte),
    .run_last   (run_last),
    .stream_done(stream_done),
    .empty      (empty),
    .pop        (pop)
  );

endmodule

[bench/utt_checker.sv]
// Checker for the UTF-16 to UTF-8 transcoder: predicts every UTF-8 byte and compares results.
module utt_checker
  import utt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic [31:0] prdata,
  input  logic        pready,
  input  logic [7:0]  in_byte,
  input  logic        end_of_stream,
  input  logic        push,
  input  logic        full,
  input  logic [7:0]  out_byte,
  input  logic        run_last,
  input  logic        stream_done,
  input  logic        empty,
  input  logic        pop,
  output int unsigned failures,
  output int unsigned pending
);

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       done;
  } utf8_byte_t;

  // UTF-8 bytes still owed by the block, oldest first
  utf8_byte_t utf8_expected[$];
  // bytes produced by the input transaction being predicted
  logic [7:0] step_bytes[$];

  // shadow of the register and the pairing state
  logic       be_mode;
  logic       pair_phase;
  logic [7:0] first_byte;
  logic       bom_possible;
  logic       high_pending;
  logic [9:0] high_payload;

  task automatic clear_pairing();
    pair_phase   = 1'b0;
    first_byte   = 8'h00;
    bom_possible = 1'b1;
    high_pending = 1'b0;
    high_payload = 10'h000;
  endtask

  // Append one byte to the current transaction's output
  task automatic add_byte(input logic [7:0] b);
    step_bytes.insert(step_bytes.size(), b);
  endtask

  task automatic put_three(input logic [15:0] u);
    add_byte(LEAD3 | {4'h0, u[15:12]});
    add_byte(CONT | {2'b00, u[11:6]});
    add_byte(CONT | {2'b00, u[5:0]});
  endtask

  // Encode a unit with no high surrogate held; hold a new high surrogate unless the stream ends
  task automatic encode_unit(input logic [15:0] u, input logic eos);
    if (u < ONE_BYTE_LIMIT) begin
      add_byte(u[7:0]);
    end else if (u < TWO_BYTE_LIMIT) begin
      add_byte(LEAD2 | {3'b000, u[10:6]});
      add_byte(CONT | {2'b00, u[5:0]});
    end else if (u >= HIGH_SURR_FIRST && u <= HIGH_SURR_LAST && !eos) begin
      high_pending = 1'b1;
      high_payload = u[9:0];
    end else begin
      put_three(u);
    end
  endtask

  // Advance the shadow state by one input byte and queue the bytes it yields
  task automatic transcode_byte(input logic [7:0] b, input logic eos);
    logic [15:0] u;
    logic [20:0] cp;
    logic        drop;
    utf8_byte_t  item;
    step_bytes.delete();
    if (!pair_phase) begin
      first_byte = b;
      pair_phase = 1'b1;
    end else begin
      pair_phase = 1'b0;
      u = be_mode ? {first_byte, b} : {b, first_byte};
      drop = bom_possible && (u == BOM_UNIT);
      bom_possible = 1'b0;
      if (!drop) begin
        if (high_pending) begin
          high_pending = 1'b0;
          if (u >= LOW_SURR_FIRST && u <= LOW_SURR_LAST) begin
            cp = SUPP_BASE + {1'b0, high_payload, u[9:0]};
            high_payload = 10'h000;
            add_byte(LEAD4 | {5'b00000, cp[20:18]});
            add_byte(CONT | {2'b00, cp[17:12]});
            add_byte(CONT | {2'b00, cp[11:6]});
            add_byte(CONT | {2'b00, cp[5:0]});
          end else begin
            high_payload = 10'h000;
            add_byte(REPL0);
            add_byte(REPL1);
            add_byte(REPL2);
            encode_unit(u, eos);
          end
        end else begin
          encode_unit(u, eos);
        end
      end
    end
    // flush a dangling high surrogate and start over at end of stream
    if (eos) begin
      if (high_pending) put_three({HIGH_SURR_PREFIX, high_payload});
      clear_pairing();
    end
    foreach (step_bytes[k]) begin
      item.data = step_bytes[k];
      item.last = (k == step_bytes.size() - 1);
      item.done = eos;
      utf8_expected.insert(utf8_expected.size(), item);
    end
  endtask

  always @(posedge clk) begin
    utf8_byte_t want;
    if (rst) begin
      be_mode  = 1'b0;
      failures = 0;
      clear_pairing();
      utf8_expected.delete();
    end else begin
      // compare an accepted result transaction with the oldest expectation
      if (pop && !empty) begin
        if (utf8_expected.size() == 0) begin
          $error("unexpected result: out_byte %h run_last %b stream_done %b",
                 out_byte, run_last, stream_done);
          failures++;
        end else begin
          want = utf8_expected.pop_front();
          if (out_byte !== want.data) begin
            $error("out_byte: expected %h, got %h", want.data, out_byte);
            failures++;
          end
          if (run_last !== want.last) begin
            $error("run_last: expected %b, got %b", want.last, run_last);
            failures++;
          end
          if (stream_done !== want.done) begin
            $error("stream_done: expected %b, got %b", want.done, stream_done);
            failures++;
          end
        end
      end
      // track register writes and check reads
      if (psel && penable && pready && paddr[2] == REG_BIG_ENDIAN) begin
        if (pwrite) begin
          be_mode = pwdata[0];
        end else if (prdata !== {31'b0, be_mode}) begin
          $error("prdata: expected %h, got %h", {31'b0, be_mode}, prdata);
          failures++;
        end
      end
      // predict an accepted input transaction
      if (push && !full) transcode_byte(in_byte, end_of_stream);
    end
    pending = utf8_expected.size();
  end

endmodule

[bench/tb_utf16_to_utf8_transcoder.sv]
// Testbench top for the UTF-16 to UTF-8 transcoder: clock, reset, stimulus and verdict.
module tb_utf16_to_utf8_transcoder;
  import utt_pkg::*;

  localparam logic [2:0]  BIG_ENDIAN_ADDR = {REG_BIG_ENDIAN, 2'b00};
  localparam int unsigned MAX_GAP         = 13;
  localparam int unsigned HOLD_CYCLES     = 200;
  localparam int unsigned SETTLE_CYCLES   = 16;
  localparam int unsigned STALL_LIMIT     = 2000;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic [7:0]  in_byte;
  logic        end_of_stream;
  logic        push;
  logic        full;
  logic [7:0]  out_byte;
  logic        run_last;
  logic        stream_done;
  logic        empty;
  logic        pop;

  int unsigned failures;
  int unsigned pending;

  // stimulus bookkeeping
  logic        cur_be;
  int unsigned sent;
  bit          tx_burst;
  bit          rx_burst;
  int unsigned hold_req;
  int unsigned rx_wait;

  utf16_to_utf8_transcoder dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_byte(in_byte), .end_of_stream(end_of_stream), .push(push), .full(full),
    .out_byte(out_byte), .run_last(run_last), .stream_done(stream_done),
    .empty(empty), .pop(pop)
  );

  utt_checker transcode_check (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_byte(in_byte), .end_of_stream(end_of_stream), .push(push), .full(full),
    .out_byte(out_byte), .run_last(run_last), .stream_done(stream_done),
    .empty(empty), .pop(pop),
    .failures(failures), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Offer one byte after a random gap and hold it until the block takes it
  task automatic send_byte(input logic [7:0] b, input logic eos);
    int unsigned gap;
    if ($urandom_range(0, 39) == 0) tx_burst = !tx_burst;
    gap = tx_burst ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    push          <= 1'b1;
    in_byte       <= b;
    end_of_stream <= eos;
    do @(posedge clk); while (full);
    sent++;
    @(negedge clk);
  endtask

  // Send one code unit in the current byte order
  task automatic send_unit(input logic [15:0] u, input logic eos);
    send_byte(cur_be ? u[15:8] : u[7:0], 1'b0);
    send_byte(cur_be ? u[7:0] : u[15:8], eos);
  endtask

  // One APB transaction: setup cycle, then access until pready
  task automatic reg_access(input logic wr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= BIG_ENDIAN_ADDR;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_byte_order(input logic be, input logic [31:0] data);
    reg_access(1'b1, data);
    reg_access(1'b0, 32'h0);
    cur_be = be;
  endtask

  // Stop offering and wait until every expected byte is out and the queue has settled
  task automatic drain();
    push <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  function automatic logic [15:0] random_unit();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 20) return 16'($urandom_range(0, 16'h007F));
    if (pick < 35) return 16'($urandom_range(16'h0080, 16'h07FF));
    if (pick < 50) return 16'($urandom_range(16'h0800, 16'hD7FF));
    if (pick < 58) return 16'($urandom_range(16'hE000, 16'hFFFF));
    if (pick < 68) return 16'($urandom_range(HIGH_SURR_FIRST, HIGH_SURR_LAST));
    if (pick < 76) return 16'($urandom_range(LOW_SURR_FIRST, LOW_SURR_LAST));
    if (pick < 80) return BOM_UNIT;
    return 16'($urandom);
  endfunction

  // Stream of random units, some of them surrogate pairs, ended on a unit or on an odd byte
  task automatic send_stream();
    int unsigned n;
    bit          tail;
    bit          last;
    n    = $urandom_range(1, 8);
    tail = ($urandom_range(0, 4) == 0);
    if ($urandom_range(0, 3) == 0) send_unit(BOM_UNIT, 1'b0);
    for (int i = 0; i < n; i++) begin
      last = (i == n - 1) && !tail;
      if ($urandom_range(0, 3) == 0) begin
        send_unit(HIGH_SURR_FIRST | 16'($urandom_range(0, 10'h3FF)), 1'b0);
        send_unit(LOW_SURR_FIRST | 16'($urandom_range(0, 10'h3FF)), last);
      end else begin
        send_unit(random_unit(), last);
      end
    end
    if (tail) send_byte(8'($urandom), 1'b1);
  endtask

  task automatic run_random(input int unsigned count);
    int unsigned stop_at;
    int unsigned n;
    stop_at = sent + count;
    while (sent < stop_at) begin
      if ($urandom_range(0, 6) != 0) begin
        send_stream();
      end else begin
        // raw bytes with a stray end of stream now and then
        n = $urandom_range(1, 10);
        repeat (n) send_byte(8'($urandom), $urandom_range(0, 7) == 0);
      end
    end
  endtask

  // Result side: pop after a random wait per transaction, or hold off on each new request
  initial begin
    int unsigned holds_taken;
    pop         = 1'b0;
    rx_wait     = 0;
    rx_burst    = 1'b0;
    holds_taken = 0;
    wait (rst === 1'b0);
    forever begin
      @(negedge clk);
      if (hold_req != holds_taken) begin
        rx_wait     = HOLD_CYCLES;
        holds_taken = hold_req;
      end
      if (rx_wait > 0) begin
        pop <= 1'b0;
        rx_wait--;
      end else begin
        pop <= 1'b1;
      end
      @(posedge clk);
      if (pop && !empty) begin
        if ($urandom_range(0, 39) == 0) rx_burst = !rx_burst;
        rx_wait = rx_burst ? 0 : $urandom_range(0, MAX_GAP);
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  initial begin
    int unsigned stall;
    stall = 0;
    while (stall < STALL_LIMIT) begin
      @(posedge clk);
      if ((push && !full) || (pop && !empty) || psel) stall = 0;
      else stall++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  // Stimulus and verdict
  initial begin
    rst           = 1'b1;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    in_byte       = '0;
    end_of_stream = 1'b0;
    push          = 1'b0;
    cur_be        = 1'b0;
    sent          = 0;
    tx_burst      = 1'b0;
    hold_req      = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset value, then little endian with the special cases
    reg_access(1'b0, 32'h0);
    set_byte_order(1'b0, 32'h0);
    send_unit(BOM_UNIT, 1'b0);             // leading byte order mark, dropped
    send_unit(16'h007F, 1'b0);
    send_unit(16'h07FF, 1'b0);
    send_unit(TWO_BYTE_LIMIT, 1'b0);
    send_unit(BOM_UNIT, 1'b0);             // later FEFF is real text
    send_unit(16'hD83D, 1'b0);             // valid surrogate pair
    send_unit(16'hDE00, 1'b0);
    send_unit(HIGH_SURR_FIRST, 1'b0);      // high surrogate, then a plain unit
    send_unit(16'h0000, 1'b0);
    send_unit(LOW_SURR_FIRST, 1'b0);       // lone low surrogate
    send_unit(16'hFFFF, 1'b0);
    send_unit(HIGH_SURR_LAST, 1'b0);       // high surrogate left at end of stream
    send_byte(8'h7F, 1'b1);                // odd final byte, dropped
    drain();

    set_byte_order(1'b1, 32'hFFFF_FFFF);
    run_random(105);
    drain();

    // long receiver hold-off so the block backs up into its input
    set_byte_order(1'b0, 32'h0000_0000);
    hold_req++;
    run_random(100);
    drain();

    set_byte_order(1'b1, 32'h0000_0001);
    run_random(100);
    drain();

    set_byte_order(1'b0, 32'hFFFF_FFFE);
    run_random(100);
    drain();

    if (failures == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

[sim.f]
sv/utt_pkg.sv
sv/utt_front.sv
sv/utt_queue.sv
sv/utt_back.sv
sv/utf16_to_utf8_transcoder.sv
bench/utt_checker.sv
bench/tb_utf16_to_utf8_transcoder.sv
